@@ hdl/avl_pkg.sv @@
// Shared types and constants of the audio VU level meter.
`default_nettype none
package avl_pkg;

	localparam int ENERGY_W    = 48;
	localparam int CNT_W       = 13;
	localparam int ACC_W       = 25;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int DIVD_W      = 48;
	localparam int DIVS_W      = 17;

	localparam logic [ENERGY_W-1:0] ENERGY_MAX   = '1;
	localparam logic [17:0]         LOG_K        = 18'd197283;
	localparam logic signed [17:0]  FS_OFFSET    = 18'sd23119;
	localparam logic signed [15:0]  ANGLE_RESET  = -16'sd11520;

	typedef enum logic [2:0] {
		CFG_ANGLE_MIN  = 3'd0,
		CFG_ANGLE_MAX  = 3'd1,
		CFG_DB_FLOOR   = 3'd2,
		CFG_DB_CEILING = 3'd3,
		CFG_ATTACK     = 3'd4,
		CFG_RELEASE    = 3'd5,
		CFG_GAIN       = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] angle_min;
		logic signed [15:0] angle_max;
		logic signed [14:0] db_floor;
		logic signed [14:0] db_ceiling;
		logic [15:0]        attack_coef;
		logic [15:0]        release_coef;
		logic [2:0]         gain_shift;
	} cfg_t;

	// one finished block handed from front to back
	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		logic [CNT_W-1:0]    count;
	} blk_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

@@ hdl/avl_if.sv @@
// Channel interfaces: samples in, levels out, register writes.
`default_nettype none
interface avl_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               block_end;
	modport source (output valid, sample, block_end, input ready);
	modport sink   (input valid, sample, block_end, output ready);
endinterface

interface avl_level_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] needle_angle;
	logic signed [14:0] level_db;
	modport source (output valid, needle_angle, level_db, input ready);
	modport sink   (input valid, needle_angle, level_db, output ready);
endinterface

interface avl_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/avl_front.sv @@
// Per-sample front end: DC removal, gain, squaring and block energy sum.
`default_nettype none
module avl_front #(
	parameter int MAX_BLOCK_SAMPLES = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	avl_sample_if.sink        samples,
	input  wire logic [2:0]   gain_shift,
	input  wire logic         space_ok,
	output logic              push,
	output avl_pkg::blk_t     push_data
);
	import avl_pkg::*;

	logic                   accept;
	logic signed [ACC_W-1:0] acc_q, shr, acc_n;
	logic signed [15:0]     filt;
	logic [CNT_W-1:0]       cnt_q, cnt_n;
	logic                   blk_last;

	logic                   valid_s1;
	logic signed [15:0]     filt_s1;
	logic                   last_s1;
	logic [CNT_W-1:0]       cnt_s1;

	logic [2:0]             g;
	logic signed [20:0]     scaled;
	logic signed [41:0]     sq;
	logic [ENERGY_W:0]      sum;
	logic [ENERGY_W-1:0]    energy_q, energy_n;

	assign samples.ready = space_ok;
	assign accept = samples.valid & samples.ready;

	always_comb begin
		shr      = acc_q >>> 8;
		acc_n    = acc_q - shr + ACC_W'(samples.sample);
		filt     = samples.sample - 16'(acc_n >>> 8);
		cnt_n    = cnt_q + 1'b1;
		blk_last = samples.block_end | (cnt_n == CNT_W'(MAX_BLOCK_SAMPLES));
	end

	// stage 2: square and saturating accumulate
	always_comb begin
		g        = (gain_shift > 3'd4) ? 3'd4 : gain_shift;
		scaled   = 21'(filt_s1) <<< g;
		sq       = scaled * scaled;
		sum      = {1'b0, energy_q} + (ENERGY_W+1)'(sq[39:0]);
		energy_n = sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			filt_s1  <= '0;
			last_s1  <= 1'b0;
			cnt_s1   <= '0;
			energy_q <= '0;
			push     <= 1'b0;
			push_data <= '0;
		end else begin
			valid_s1 <= accept;
			push     <= 1'b0;
			if (accept) begin
				acc_q   <= acc_n;
				cnt_q   <= blk_last ? '0 : cnt_n;
				filt_s1 <= filt;
				last_s1 <= blk_last;
				cnt_s1  <= cnt_n;
			end
			if (valid_s1) begin
				if (last_s1) begin
					push             <= 1'b1;
					push_data.energy <= energy_n;
					push_data.count  <= cnt_s1;
					energy_q         <= '0;
				end else begin
					energy_q <= energy_n;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/avl_fifo.sv @@
// Short block queue between front and back end.
`default_nettype none
module avl_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire avl_pkg::blk_t push_data,
	input  wire logic          pop,
	output logic               empty,
	output logic               space_ok,
	output avl_pkg::blk_t      head
);
	import avl_pkg::*;

	blk_t              mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   fill_q;

	assign empty    = (fill_q == '0);
	// two items may still be in flight inside the front end
	assign space_ok = (fill_q <= (QPTR_W+1)'(QUEUE_DEPTH - 3));
	assign head     = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			fill_q <= fill_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule
`default_nettype wire

@@ hdl/avl_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module avl_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire avl_pkg::div_req_t req,
	output avl_pkg::div_rsp_t      rsp
);
	import avl_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [5:0]        bit_q;
	logic [DIVS_W-1:0] div_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVD_W-1:0] sh_q;
	logic [DIVS_W:0]   trial;
	logic              qbit;

	always_comb begin
		trial = {rem_q, sh_q[DIVD_W-1]};
		qbit  = (trial >= {1'b0, div_q});
	end

	assign rsp.quotient = sh_q;
	assign rsp.done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
			sh_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				bit_q  <= 6'(DIVD_W - 1);
				div_q  <= req.divisor;
				rem_q  <= '0;
				sh_q   <= req.dividend;
			end else if (busy_q) begin
				rem_q <= qbit ? DIVS_W'(trial - {1'b0, div_q}) : trial[DIVS_W-1:0];
				sh_q  <= {sh_q[DIVD_W-2:0], qbit};
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/avl_back.sv @@
// Per-block back end: mean, log level, clamp, needle mapping and smoothing.
`default_nettype none
module avl_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire avl_pkg::cfg_t cfg_r,
	input  wire logic          empty,
	input  wire avl_pkg::blk_t head,
	output logic               pop,
	avl_level_if.source        levels
);
	import avl_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MEAN, ST_NORM, ST_SQ_MUL, ST_SQ_ADJ, ST_LOG_MUL, ST_LVL,
		ST_CLAMP, ST_MAP_MUL, ST_MAP_DIV_GO, ST_MAP_DIV, ST_SM_MUL, ST_SM_ADD, ST_OUT
	} state_t;

	state_t                  state_q;
	div_req_t                dreq;
	div_rsp_t                drsp;

	logic [DIVD_W-1:0]       norm_q;
	logic [5:0]              e_q;
	logic [31:0]             m_q;
	logic [61:0]             prod_q;
	logic [15:0]             frac_q;
	logic [3:0]              step_q;
	logic [39:0]             p_q;
	logic signed [17:0]      lvl_q;
	logic signed [14:0]      lvl_c_q;
	logic signed [32:0]      num_q;
	logic                    neg_q;
	logic signed [18:0]      target_q;
	logic signed [36:0]      smp_q;
	logic signed [15:0]      sm_q;
	logic                    out_valid_q;
	logic signed [15:0]      out_angle_q;
	logic signed [14:0]      out_db_q;

	logic [31:0]             sq_t;
	logic [40:0]             pr;
	logic signed [17:0]      lvl_n, floor18, ceil18, clamp_n;
	logic signed [15:0]      span_l;
	logic signed [16:0]      span_a;
	logic [15:0]             den;
	logic [32:0]             mag;
	logic [17:0]             q;
	logic signed [18:0]      qs;
	logic signed [19:0]      dlt;
	logic [15:0]             coef;
	logic signed [20:0]      stepv;

	avl_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		floor18 = 18'(cfg_r.db_floor);
		ceil18  = 18'(cfg_r.db_ceiling);
		sq_t    = prod_q[61:30];
		pr      = {1'b0, p_q} + 41'(24'h800000);
		lvl_n   = $signed({1'b0, pr[40:24]}) - FS_OFFSET;
		clamp_n = (lvl_q > ceil18) ? ceil18 : lvl_q;
		clamp_n = (clamp_n < floor18) ? floor18 : clamp_n;
		span_l  = 16'(lvl_c_q) - 16'(cfg_r.db_floor);
		span_a  = 17'(cfg_r.angle_max) - 17'(cfg_r.angle_min);
		den     = 16'(ceil18 - floor18);
		mag     = num_q[32] ? 33'(-num_q) : 33'(num_q);
		q       = drsp.quotient[17:0];
		qs      = neg_q ? -$signed({1'b0, q}) : $signed({1'b0, q});
		dlt     = 20'(target_q) - 20'(sm_q);
		coef    = (dlt > 20'sd0) ? cfg_r.attack_coef : cfg_r.release_coef;
		stepv   = 21'((smp_q + 37'sd32768) >>> 16);

		pop           = (state_q == ST_IDLE) && !empty;
		dreq.start    = pop || (state_q == ST_MAP_DIV_GO);
		dreq.dividend = (state_q == ST_IDLE) ? head.energy
		                                     : DIVD_W'({mag, 1'b0}) + DIVD_W'(den);
		dreq.divisor  = (state_q == ST_IDLE) ? DIVS_W'(head.count) : {den, 1'b0};
	end

	assign levels.valid        = out_valid_q;
	assign levels.needle_angle = out_angle_q;
	assign levels.level_db     = out_db_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			norm_q      <= '0;
			e_q         <= '0;
			m_q         <= '0;
			prod_q      <= '0;
			frac_q      <= '0;
			step_q      <= '0;
			p_q         <= '0;
			lvl_q       <= '0;
			lvl_c_q     <= '0;
			num_q       <= '0;
			neg_q       <= 1'b0;
			target_q    <= '0;
			smp_q       <= '0;
			sm_q        <= ANGLE_RESET;
			out_valid_q <= 1'b0;
			out_angle_q <= '0;
			out_db_q    <= '0;
		end else begin
			if (out_valid_q && levels.ready && (state_q != ST_OUT)) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					if (drsp.done) begin
						if (drsp.quotient == '0) begin
							lvl_q   <= floor18;
							state_q <= ST_CLAMP;
						end else begin
							norm_q  <= drsp.quotient;
							e_q     <= 6'(DIVD_W - 1);
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					if (norm_q[DIVD_W-1]) begin
						m_q     <= {1'b0, norm_q[DIVD_W-1:DIVD_W-31]};
						frac_q  <= '0;
						step_q  <= '0;
						state_q <= ST_SQ_MUL;
					end else begin
						norm_q <= norm_q << 1;
						e_q    <= e_q - 1'b1;
					end
				end
				ST_SQ_MUL: begin
					prod_q  <= m_q[30:0] * m_q[30:0];
					state_q <= ST_SQ_ADJ;
				end
				ST_SQ_ADJ: begin
					m_q    <= sq_t[31] ? {1'b0, sq_t[31:1]} : sq_t;
					frac_q <= {frac_q[14:0], sq_t[31]};
					step_q <= step_q + 1'b1;
					state_q <= (step_q == 4'hF) ? ST_LOG_MUL : ST_SQ_MUL;
				end
				ST_LOG_MUL: begin
					p_q     <= {e_q, frac_q} * LOG_K;
					state_q <= ST_LVL;
				end
				ST_LVL: begin
					lvl_q   <= lvl_n;
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					lvl_c_q <= clamp_n[14:0];
					if (ceil18 <= floor18) begin
						target_q <= 19'(cfg_r.angle_min);
						state_q  <= ST_SM_MUL;
					end else begin
						state_q <= ST_MAP_MUL;
					end
				end
				ST_MAP_MUL: begin
					num_q   <= span_l * span_a;
					state_q <= ST_MAP_DIV_GO;
				end
				ST_MAP_DIV_GO: begin
					neg_q   <= num_q[32];
					state_q <= ST_MAP_DIV;
				end
				ST_MAP_DIV: begin
					if (drsp.done) begin
						target_q <= 19'(cfg_r.angle_min) + qs;
						state_q  <= ST_SM_MUL;
					end
				end
				ST_SM_MUL: begin
					smp_q   <= dlt * $signed({1'b0, coef});
					state_q <= ST_SM_ADD;
				end
				ST_SM_ADD: begin
					sm_q    <= sm_q + stepv[15:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || levels.ready) begin
						out_valid_q <= 1'b1;
						out_angle_q <= sm_q;
						out_db_q    <= lvl_c_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/audio_vu_level_meter.sv @@
// Top level of the audio VU level meter: register file, front end, queue, back end.
//
// Channels: 'samples' carries one signed 16-bit sample and a block_end flag per
// transaction; 'levels' carries one needle_angle / level_db pair per finished
// block; 'cfg' writes a register by index (always ready, write while idle).
// Front end takes one sample every cycle while ready is high: DC removal in
// the accept cycle, squaring and the saturating energy sum in the next cycle.
// A block ends on block_end or when MAX_BLOCK_SAMPLES samples have been taken.
// Back end, per block: restoring divide for the mean, a normalising shift,
// 16 squaring steps of a multiply and an adjust state each, log scale and
// clamp, a second pass through the same divider for the needle mapping,
// then the attack/release multiply. A zero mean goes straight to the clamp,
// and a ceiling at or below the floor skips the mapping divide.
// Blocks queue four deep; samples stall (ready low) once two blocks wait in
// the queue, as two more may still be on their way through the front end.
// A finished block passes the stage-1 and push registers, then the queue and back end.
// A stalled receiver holds the result register; the back end waits behind it
// and the queue absorbs further blocks.
// Reset clears all sums and counters, loads register defaults and puts the
// needle at the reset floor angle.
`default_nettype none
module audio_vu_level_meter #(
	parameter int MAX_BLOCK_SAMPLES = 256
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	avl_sample_if.sink  samples,
	avl_level_if.source levels,
	avl_cfg_if.sink     cfg
);
	import avl_pkg::*;

	cfg_t cfg_q;
	logic push, pop, empty, space_ok;
	blk_t push_data, head;

	assign cfg.ready = 1'b1;

	// register file; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_min    <= -16'sd11520;
			cfg_q.angle_max    <= 16'sd11520;
			cfg_q.db_floor     <= -15'sd9216;
			cfg_q.db_ceiling   <= -15'sd1536;
			cfg_q.attack_coef  <= 16'd22938;
			cfg_q.release_coef <= 16'd5243;
			cfg_q.gain_shift   <= 3'd2;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ANGLE_MIN:  cfg_q.angle_min    <= cfg.data;
				CFG_ANGLE_MAX:  cfg_q.angle_max    <= cfg.data;
				CFG_DB_FLOOR:   cfg_q.db_floor     <= cfg.data[14:0];
				CFG_DB_CEILING: cfg_q.db_ceiling   <= cfg.data[14:0];
				CFG_ATTACK:     cfg_q.attack_coef  <= cfg.data;
				CFG_RELEASE:    cfg_q.release_coef <= cfg.data;
				CFG_GAIN:       cfg_q.gain_shift   <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	avl_front #(.MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)) u_front (
		.clk(clk), .arst_n(arst_n), .samples(samples),
		.gain_shift(cfg_q.gain_shift), .space_ok(space_ok),
		.push(push), .push_data(push_data)
	);

	avl_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .empty(empty), .space_ok(space_ok), .head(head)
	);

	avl_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_r(cfg_q), .empty(empty),
		.head(head), .pop(pop), .levels(levels)
	);

endmodule
`default_nettype wire

@@ tb/audio_vu_level_meter_tb.sv @@
// Self-checking testbench of the audio VU level meter.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import avl_pkg::*;

	localparam int MAX_BLK = 256;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 400;

	logic clk;
	logic arst_n;

	avl_sample_if samples_if ();
	avl_level_if  levels_if ();
	avl_cfg_if    cfg_if ();

	audio_vu_level_meter #(.MAX_BLOCK_SAMPLES(MAX_BLK)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if.sink),
		.levels(levels_if.source),
		.cfg(cfg_if.sink)
	);

	// expected level transaction
	typedef struct {
		logic signed [15:0] needle;
		logic signed [14:0] level;
	} level_t;

	level_t level_q[$];
	int     fail_count;
	int     idle_cycles;
	bit     hold_off;     // long receiver hold-off requested
	bit     idle_gaps;    // random gaps on both sides enabled

	// predictor state and register copies
	logic signed [15:0] m_angle_min, m_angle_max;
	logic signed [14:0] m_floor, m_ceil;
	logic [15:0]        m_attack, m_release;
	logic [2:0]         m_gain;
	logic signed [24:0] m_acc;
	logic [47:0]        m_energy;
	int unsigned        m_count;
	logic signed [15:0] m_needle;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (levels_if.valid && levels_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("audio_vu_level_meter: mismatch");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_gaps || r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// fixed-point log2 in Q16, mean >= 1
	function automatic logic [31:0] log2_q16(logic [47:0] x);
		int          e;
		logic [15:0] frac;
		logic [63:0] m;
		logic [127:0] p;
		e = 0;
		while (e < 47 && (x >> (e + 1)) != 0) e++;
		m = (e >= 30) ? (64'(x) >> (e - 30)) : (64'(x) << (30 - e));
		frac = '0;
		for (int i = 0; i < 16; i++) begin
			p = 128'(m) * 128'(m);
			m = 64'(p >> 30);
			frac = frac << 1;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return {16'(e), frac};
	endfunction

	// floor division, divisor positive
	function automatic longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) q -= 1;
		return q;
	endfunction

	// one sample through the meter; returns 1 when a block finishes
	function automatic bit meter_step(logic signed [15:0] s, logic last, output level_t res);
		longint shr, acc, scaled, num, den, q, d, lvl, target;
		logic [63:0]  sq;
		logic [47:0]  mean;
		logic [15:0]  coef;
		logic signed [15:0] filt;
		int g;
		g = (m_gain > 4) ? 4 : m_gain;
		shr = fdiv(longint'(m_acc), 256);
		acc = longint'(m_acc) - shr + s;
		m_acc = 25'(acc);
		shr = fdiv(longint'(m_acc), 256);
		filt = 16'(longint'(s) - shr);
		scaled = longint'(filt) * (longint'(1) << g);
		sq = 64'(scaled * scaled);
		if (64'(ENERGY_MAX) - 64'(m_energy) < sq) m_energy = ENERGY_MAX;
		else m_energy = 48'(64'(m_energy) + sq);
		m_count++;
		if (!last && m_count < MAX_BLK) return 0;
		mean = m_energy / 48'(m_count);
		if (mean < 1)
			lvl = m_floor;
		else
			lvl = longint'((64'(log2_q16(mean)) * 64'(LOG_K) + 64'h80_0000) >> 24) - 23119;
		if (lvl > m_ceil) lvl = m_ceil;
		if (lvl < m_floor) lvl = m_floor;
		if (m_ceil <= m_floor) begin
			target = m_angle_min;
		end else begin
			den = longint'(m_ceil) - m_floor;
			num = (lvl - m_floor) * (longint'(m_angle_max) - m_angle_min);
			q = (num >= 0) ? (2 * num + den) / (2 * den) : -((-2 * num + den) / (2 * den));
			target = m_angle_min + q;
		end
		coef = (target > m_needle) ? m_attack : m_release;
		d = target - m_needle;
		m_needle = 16'(longint'(m_needle) + fdiv(d * longint'(coef) + 32768, 65536));
		m_energy = '0;
		m_count = 0;
		res.needle = m_needle;
		res.level = 15'(lvl);
		return 1;
	endfunction

	task automatic report(string what, longint got, longint want);
		fail_count++;
		$display("level check: %s got %0d expected %0d", what, got, want);
	endtask

	// sends one sample transaction and records its expectation
	task automatic send_sample(logic signed [15:0] s, logic last);
		level_t res;
		int g;
		samples_if.valid     <= 1'b1;
		samples_if.sample    <= s;
		samples_if.block_end <= last;
		do @(posedge clk); while (!samples_if.ready);
		if (meter_step(s, last, res)) level_q.push_back(res);
		g = gap_len();
		if (g != 0) begin
			samples_if.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		samples_if.valid <= 1'b0;
		while (level_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_ANGLE_MIN:  m_angle_min = val;
			CFG_ANGLE_MAX:  m_angle_max = val;
			CFG_DB_FLOOR:   m_floor     = val[14:0];
			CFG_DB_CEILING: m_ceil      = val[14:0];
			CFG_ATTACK:     m_attack    = val;
			CFG_RELEASE:    m_release   = val;
			CFG_GAIN:       m_gain      = val[2:0];
			default: ;
		endcase
	endtask

	task automatic write_all(int amin, int amax, int fl, int ce, int at, int rl, int gs);
		write_reg(CFG_ANGLE_MIN, 16'(amin));
		write_reg(CFG_ANGLE_MAX, 16'(amax));
		write_reg(CFG_DB_FLOOR, 16'(fl));
		write_reg(CFG_DB_CEILING, 16'(ce));
		write_reg(CFG_ATTACK, 16'(at));
		write_reg(CFG_RELEASE, 16'(rl));
		write_reg(CFG_GAIN, 16'(gs));
		cfg_if.valid <= 1'b0;
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (levels_if.valid && levels_if.ready) begin
			if (level_q.size() == 0) begin
				report("unexpected transaction", levels_if.needle_angle, 0);
			end else begin
				if (levels_if.needle_angle !== level_q[0].needle)
					report("needle_angle", levels_if.needle_angle, level_q[0].needle);
				if (levels_if.level_db !== level_q[0].level)
					report("level_db", levels_if.level_db, level_q[0].level);
				void'(level_q.pop_front());
			end
		end
	end

	initial begin
		int stall;
		levels_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				levels_if.ready <= 1'b0;
				stall = 0;
				while (stall < 3000) begin
					@(posedge clk);
					stall++;
				end
				hold_off = 0;
			end
			levels_if.ready <= (gap_len() == 0);
		end
	end

	// sample value: extremes, loud, quiet or any
	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return ($urandom_range(0, 1)) ? 16'sh7FFF : -16'sh8000;
			1: return 16'($signed($urandom_range(0, 16)) - 8);
			2: return 16'($signed($urandom_range(0, 512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_block(int len, bit loud);
		for (int i = 0; i < len; i++)
			send_sample(loud ? rand_sample() : 16'($signed($urandom_range(0, 4)) - 2),
				i == len - 1);
	endtask

	task automatic test_directed();
		send_sample(16'sh7FFF, 1'b0);
		send_sample(-16'sh8000, 1'b1);       // loud two-sample block
		send_sample(16'sd0, 1'b1);           // silence: floor level
		send_sample(16'sd1, 1'b1);
		send_sample(-16'sh8000, 1'b1);
		send_block(4, 1);
		send_block(8, 0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh7FFF, 1'b1);
		drain();
	endtask

	task automatic test_long_block();
		// block too long: count limit ends it, plus DC accumulator pressure
		for (int i = 0; i < MAX_BLK + 10; i++) send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh7FFF, 1'b1);
		drain();
	endtask

	task automatic test_config_extremes();
		write_all(-23040, 23040, -16384, 0, 65535, 0, 7);   // gain too large
		send_block(3, 1);
		send_block(3, 1);
		drain();
		write_all(23040, -23040, 0, -16384, 0, 65535, 0);   // ceiling below floor
		send_block(3, 1);
		send_block(5, 0);
		drain();
		write_all(100, 200, -4000, -4000, 30000, 30000, 4); // ceiling equals floor
		send_block(3, 1);
		drain();
		write_all(-11520, 11520, -9216, -1536, 22938, 5243, 2);
		send_block(4, 1);
		drain();
	endtask

	task automatic test_backpressure();
		// receiver holds off while short blocks fill the queue
		hold_off = 1;
		for (int b = 0; b < 12; b++) send_block(3, 1);
		drain();
	endtask

	task automatic test_random(int items);
		int sent, len, r;
		sent = 0;
		while (sent < items) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				drain();
				write_all($urandom_range(0, 46080) - 23040, $urandom_range(0, 46080) - 23040,
					-$urandom_range(0, 16384), -$urandom_range(0, 16384),
					$urandom, $urandom, $urandom_range(0, 7));
			end
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
			send_block(len, $urandom_range(0, 4) != 0);
			sent += len;
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		samples_if.valid = 1'b0;
		samples_if.sample = '0;
		samples_if.block_end = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_ANGLE_MIN;
		cfg_if.data = '0;
		fail_count = 0;
		idle_cycles = 0;
		hold_off = 0;
		idle_gaps = 0;
		m_angle_min = -16'sd11520; m_angle_max = 16'sd11520;
		m_floor = -15'sd9216; m_ceil = -15'sd1536;
		m_attack = 16'd22938; m_release = 16'd5243; m_gain = 3'd2;
		m_acc = '0; m_energy = '0; m_count = 0; m_needle = -16'sd11520;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();          // no idling on either side
		idle_gaps = 1;
		test_long_block();
		test_config_extremes();
		test_backpressure();
		test_random(1350);
		if (fail_count == 0)
			$display("audio_vu_level_meter: match");
		else
			$display("audio_vu_level_meter: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

@@ files.f @@
hdl/avl_pkg.sv
hdl/avl_if.sv
hdl/avl_front.sv
hdl/avl_fifo.sv
hdl/avl_div.sv
hdl/avl_back.sv
hdl/audio_vu_level_meter.sv
tb/audio_vu_level_meter_tb.sv
